// ----- rtl/hltp_pkg.sv -----
// ----------------------------------------------------------------------------
// hltp_pkg: shared types and constants for the linear probing hash table
// slot count, probe limit, request and status codes, hash function
// ----------------------------------------------------------------------------
package hltp_pkg;

    localparam int CAPACITY    = 256;
    localparam int SLOT_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int PROBE_LIMIT = CAPACITY / 2;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    // slot memory write port
    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_key   key;
        t_value value;
    } t_slot_wr;

    function automatic logic [31:0] fold16(input logic [31:0] x);
        fold16 = x ^ {16'd0, x[31:16]};
    endfunction

endpackage

// ----- rtl/hltp_if.sv -----
// ----------------------------------------------------------------------------
// hltp_req_if / hltp_rsp_if: valid/ready channels of the hash table
// request carries type, key and value; response carries status, value, count
// ----------------------------------------------------------------------------
interface hltp_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    hltp_pkg::t_key       key;
    hltp_pkg::t_value     value_in;

    modport source (output valid, req_type, key, value_in, input ready);
    modport sink   (input valid, req_type, key, value_in, output ready);
endinterface

interface hltp_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    hltp_pkg::t_value          value_out;
    hltp_pkg::t_count          entry_count;

    modport source (output valid, status, value_out, entry_count, input ready);
    modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

// ----- rtl/hltp_hash.sv -----
// ----------------------------------------------------------------------------
// hltp_hash: pipelined home slot hash
// two xor-shift-multiply rounds, one register after each multiply
// ----------------------------------------------------------------------------
module hltp_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  hltp_pkg::t_key       i_key,
    output logic                 o_done,
    output hltp_pkg::t_slot      o_slot
);
    logic [31:0] r_h1, r_h2;
    logic [1:0]  r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1 <= hltp_pkg::fold16(i_key) * hltp_pkg::HASH_MUL;
        r_h2 <= hltp_pkg::fold16(r_h1) * hltp_pkg::HASH_MUL;
    end

    logic [31:0] w_fin;
    assign w_fin  = hltp_pkg::fold16(r_h2);
    assign o_slot = w_fin[hltp_pkg::SLOT_BITS-1:0];
    assign o_done = r_vld[1];
endmodule

// ----- rtl/hltp_slot_ram.sv -----
// ----------------------------------------------------------------------------
// hltp_slot_ram: slot key/value memory, one write and one read port
// keys are zero until written through a per-slot valid bit
// ----------------------------------------------------------------------------
module hltp_slot_ram (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hltp_pkg::t_slot_wr    i_wr,
    input  hltp_pkg::t_slot       i_rd_addr,
    output hltp_pkg::t_key        o_rd_key,
    output hltp_pkg::t_value      o_rd_value
);
    hltp_pkg::t_key   mem_key [hltp_pkg::CAPACITY];
    hltp_pkg::t_value mem_val [hltp_pkg::CAPACITY];
    logic [hltp_pkg::CAPACITY-1:0] r_written;
    hltp_pkg::t_key   r_key;
    hltp_pkg::t_value r_val;
    logic             r_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_key[i_wr.addr] <= i_wr.key;
            mem_val[i_wr.addr] <= i_wr.value;
        end
        r_key <= mem_key[i_rd_addr];
        r_val <= mem_val[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_ok      <= 1'b0;
        end else begin
            if (i_wr.en) r_written[i_wr.addr] <= 1'b1;
            r_ok <= r_written[i_rd_addr];
        end
    end

    assign o_rd_key   = r_ok ? r_key : '0;
    assign o_rd_value = r_val;
endmodule

// ----- rtl/hltp_ctrl.sv -----
// ----------------------------------------------------------------------------
// hltp_ctrl: request sequencer
// probes slots one at a time (read, then check), inserts, and backward-shifts on removal
// ----------------------------------------------------------------------------
module hltp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hltp_req_if.sink             req,
    hltp_rsp_if.source           rsp,
    output logic                 o_hash_start,
    output hltp_pkg::t_key       o_hash_key,
    input  logic                 i_hash_done,
    input  hltp_pkg::t_slot      i_hash_slot,
    output hltp_pkg::t_slot_wr   o_wr,
    output hltp_pkg::t_slot      o_rd_addr,
    input  hltp_pkg::t_key       i_rd_key,
    input  hltp_pkg::t_value     i_rd_value
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HASH  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_SRD   = 8'b0001_0000,
        S_SCHK  = 8'b0010_0000,
        S_SHASH = 8'b0100_0000,
        S_SMOVE = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    hltp_pkg::t_req      r_req, n_req;
    hltp_pkg::t_key      r_key, n_key;
    hltp_pkg::t_value    r_val, n_val;
    hltp_pkg::t_slot     r_idx, n_idx;
    hltp_pkg::t_slot     r_hole, n_hole;
    hltp_pkg::t_count    r_steps, n_steps;
    hltp_pkg::t_count    r_cnt, n_cnt;
    hltp_pkg::t_key      r_skey, n_skey;
    hltp_pkg::t_value    r_sval, n_sval;
    logic                r_ovld, n_ovld;
    logic [2:0]          r_ost, n_ost;
    hltp_pkg::t_value    r_oval, n_oval;

    hltp_pkg::t_slot     w_dhome, w_dhole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_key   <= n_key;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_hole  <= n_hole;
        r_steps <= n_steps;
        r_skey  <= n_skey;
        r_sval  <= n_sval;
        r_ost   <= n_ost;
        r_oval  <= n_oval;
    end

    assign req.ready       = (r_state == S_IDLE) && !r_ovld;
    assign rsp.valid       = r_ovld;
    assign rsp.status      = r_ost;
    assign rsp.value_out   = r_oval;
    assign rsp.entry_count = r_cnt;
    assign o_rd_addr       = r_idx;
    assign o_hash_key      = (r_state == S_IDLE) ? req.key : r_skey;

    assign w_dhome = r_idx - i_hash_slot;
    assign w_dhole = r_idx - r_hole;

    always_comb begin
        n_state = r_state;
        n_req = r_req; n_key = r_key; n_val = r_val; n_idx = r_idx;
        n_hole = r_hole; n_steps = r_steps; n_cnt = r_cnt;
        n_skey = r_skey; n_sval = r_sval;
        n_ovld = r_ovld; n_ost = r_ost; n_oval = r_oval;
        o_hash_start = 1'b0;
        o_wr = '0;
        if (rsp.valid && rsp.ready) n_ovld = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (req.valid && req.ready) begin
                    n_req = hltp_pkg::t_req'(req.req_type);
                    n_key = req.key;
                    n_val = req.value_in;
                    n_steps = '0;
                    n_ost = hltp_pkg::ST_NOT_FOUND;
                    n_oval = '0;
                    if (req.key == '0) begin
                        n_ost = hltp_pkg::ST_INVALID;
                        n_ovld = 1'b1;
                    end else if (hltp_pkg::t_req'(req.req_type) == hltp_pkg::REQ_NONE) begin
                        n_ovld = 1'b1;
                    end else begin
                        o_hash_start = 1'b1;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (i_hash_done) begin
                    n_idx = i_hash_slot;
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                n_state = S_IDLE;
                if (i_rd_key == '0) begin
                    if (r_req == hltp_pkg::REQ_INSERT) begin
                        o_wr = '{en: 1'b1, addr: r_idx, key: r_key, value: r_val};
                        n_cnt = r_cnt + 1'b1;
                        n_ost = hltp_pkg::ST_OK;
                        n_oval = r_val;
                    end
                    n_ovld = 1'b1;
                end else if (i_rd_key == r_key) begin
                    if (r_req == hltp_pkg::REQ_FIND) begin
                        n_ost = hltp_pkg::ST_OK;
                        n_oval = i_rd_value;
                        n_ovld = 1'b1;
                    end else if (r_req == hltp_pkg::REQ_INSERT) begin
                        n_ost = hltp_pkg::ST_PRESENT;
                        n_ovld = 1'b1;
                    end else begin
                        // remove: clear and start backward shift
                        o_wr = '{en: 1'b1, addr: r_idx, key: '0, value: '0};
                        n_cnt = r_cnt - 1'b1;
                        n_ost = hltp_pkg::ST_OK;
                        n_hole = r_idx;
                        n_idx = r_idx + 1'b1;
                        n_steps = hltp_pkg::t_count'(1);
                        n_state = S_SRD;
                    end
                end else if (r_steps == hltp_pkg::t_count'(hltp_pkg::PROBE_LIMIT - 1)) begin
                    if (r_req == hltp_pkg::REQ_INSERT) n_ost = hltp_pkg::ST_FULL;
                    n_ovld = 1'b1;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                if (i_rd_key == '0) begin
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_skey = i_rd_key;
                    n_sval = i_rd_value;
                    n_state = S_SHASH;
                end
            end
            S_SHASH: begin
                o_hash_start = 1'b1;
                n_state = S_SMOVE;
            end
            S_SMOVE: begin
                if (i_hash_done) begin
                    if (w_dhome >= w_dhole) begin
                        o_wr = '{en: 1'b1, addr: r_hole, key: r_skey, value: r_sval};
                        n_hole = r_idx;
                    end
                    n_state = S_HASH;
                    if (r_steps == hltp_pkg::t_count'(hltp_pkg::CAPACITY - 1)) begin
                        n_ovld = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_steps = r_steps + 1'b1;
                        n_idx = r_idx + 1'b1;
                        n_state = S_SRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // the vacated slot of a moved entry is cleared by hltp_mover with a second write
    end
endmodule

// ----- rtl/hltp_mover.sv -----
// ----------------------------------------------------------------------------
// hltp_mover: write merge for backward shift
// a move writes the hole, then clears the source slot on the next cycle
// ----------------------------------------------------------------------------
module hltp_mover (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hltp_pkg::t_slot_wr   i_wr,
    input  hltp_pkg::t_slot      i_src,
    input  logic                 i_move,
    output hltp_pkg::t_slot_wr   o_wr
);
    logic            r_clr;
    hltp_pkg::t_slot r_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= 1'b0;
        else          r_clr <= i_move;
        r_src <= i_src;
    end

    // controller never writes in the cycle after a move
    always_comb begin
        o_wr = i_wr;
        if (r_clr) o_wr = '{en: 1'b1, addr: r_src, key: '0, value: '0};
    end
endmodule

// ----- rtl/hash_table_linear_probe.sv -----
// ----------------------------------------------------------------------------
// hash_table_linear_probe: 256-slot key/value table, linear probing
// find/insert/remove with backward-shift deletion
// ----------------------------------------------------------------------------
// One request at a time. A request is hashed, then each probed slot is read
// and compared (registered memory read, then compare), up to 128 slots. A remove
// then walks following slots up to the first empty one, reading and checking
// each and rehashing each walked key in the shared hash pipeline. A
// result waits in an output register; the next request is taken once it
// has been transferred. Key 0 answers invalid at once.
module hash_table_linear_probe (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hltp_req_if.sink    req,
    hltp_rsp_if.source  rsp
);
    logic                 w_hstart, w_hdone;
    hltp_pkg::t_key       w_hkey, w_rkey;
    hltp_pkg::t_slot      w_hslot, w_raddr;
    hltp_pkg::t_value     w_rval;
    hltp_pkg::t_slot_wr   w_cwr, w_wr;

    hltp_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_hstart), .i_key(w_hkey),
        .o_done(w_hdone), .o_slot(w_hslot)
    );

    hltp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
        .o_hash_start(w_hstart), .o_hash_key(w_hkey), .i_hash_done(w_hdone),
        .i_hash_slot(w_hslot), .o_wr(w_cwr), .o_rd_addr(w_raddr),
        .i_rd_key(w_rkey), .i_rd_value(w_rval)
    );

    // a write carrying a nonzero key to a slot other than the read slot is a move
    logic w_move;
    assign w_move = w_cwr.en && (w_cwr.key != '0) && (w_cwr.addr != w_raddr);

    hltp_mover u_mover (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_cwr), .i_src(w_raddr),
        .i_move(w_move), .o_wr(w_wr)
    );

    hltp_slot_ram u_ram (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_wr), .i_rd_addr(w_raddr),
        .o_rd_key(w_rkey), .o_rd_value(w_rval)
    );
endmodule

// ----- rtl/hltp_checker.sv -----
// ----------------------------------------------------------------------------
// hltp_checker: port-level checks of the hash table
// response hold under stall, no request while pending, status, value and count
// ----------------------------------------------------------------------------
module hltp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [2:0]       rsp_status,
    input logic [31:0]      rsp_value,
    input logic [8:0]       rsp_count
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("response changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while response pending");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_status <= hltp_pkg::ST_INVALID)
        else $error("bad status code");
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status != hltp_pkg::ST_OK |-> rsp_value == 32'd0)
        else $error("value on failed request");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_count <= 9'd256)
        else $error("count overflow");
endmodule

bind hash_table_linear_probe hltp_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_value(rsp.value_out), .rsp_count(rsp.entry_count)
);

// ----- bench/tb_hash_table_linear_probe.sv -----
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probe: self-checking bench for the hash table
// drives find/insert/remove and unused-type requests with random gaps and back-pressure;
// a local table copy predicts status, value and entry count of every response
// ----------------------------------------------------------------------------
module tb_hash_table_linear_probe;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        hltp_pkg::t_status status;
        hltp_pkg::t_value  value;
        hltp_pkg::t_count  count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hltp_req_if req_ch ();
    hltp_rsp_if rsp_ch ();

    hash_table_linear_probe dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // shadow table
    hltp_pkg::t_key    shadow_key [hltp_pkg::CAPACITY];
    hltp_pkg::t_value  shadow_val [hltp_pkg::CAPACITY];
    int                shadow_entries;

    t_answer           answers_due [$];
    bit                failed;
    bit                send_idle_on;
    bit                recv_idle_on;
    hltp_pkg::t_key    key_pool [$];

    function automatic hltp_pkg::t_slot home_of(input hltp_pkg::t_key k);
        logic [31:0] h;
        h = k;
        h = ((h >> 16) ^ h) * hltp_pkg::HASH_MUL;
        h = ((h >> 16) ^ h) * hltp_pkg::HASH_MUL;
        h = (h >> 16) ^ h;
        return h[hltp_pkg::SLOT_BITS-1:0];
    endfunction

    // slot holding the key, or the first empty one when asked; -1 if none
    function automatic int locate(input hltp_pkg::t_key k, input bit want_empty);
        hltp_pkg::t_slot idx;
        idx = home_of(k);
        for (int i = 0; i < hltp_pkg::PROBE_LIMIT; i++) begin
            if (shadow_key[idx] == '0) return want_empty ? int'(idx) : -1;
            if (shadow_key[idx] == k) return int'(idx);
            idx = idx + 1'b1;
        end
        return -1;
    endfunction

    function automatic void shift_back(input hltp_pkg::t_slot hole);
        hltp_pkg::t_slot j;
        hltp_pkg::t_slot d_home;
        hltp_pkg::t_slot d_hole;
        j = hole + 1'b1;
        shadow_key[hole] = '0;
        shadow_val[hole] = '0;
        shadow_entries--;
        for (int i = 1; i < hltp_pkg::CAPACITY; i++) begin
            if (shadow_key[j] == '0) break;
            d_home = j - home_of(shadow_key[j]);
            d_hole = j - hole;
            if (d_home >= d_hole) begin
                shadow_key[hole] = shadow_key[j];
                shadow_val[hole] = shadow_val[j];
                shadow_key[j] = '0;
                shadow_val[j] = '0;
                hole = j;
            end
            j = j + 1'b1;
        end
    endfunction

    function automatic t_answer apply_request(input hltp_pkg::t_req op,
                                              input hltp_pkg::t_key k,
                                              input hltp_pkg::t_value v);
        t_answer a;
        int      pos;
        a.status = hltp_pkg::ST_NOT_FOUND;
        a.value  = '0;
        if (k == '0) begin
            a.status = hltp_pkg::ST_INVALID;
        end else if (op == hltp_pkg::REQ_FIND) begin
            pos = locate(k, 1'b0);
            if (pos >= 0) begin
                a.status = hltp_pkg::ST_OK;
                a.value  = shadow_val[pos];
            end
        end else if (op == hltp_pkg::REQ_INSERT) begin
            pos = locate(k, 1'b1);
            if (pos < 0) begin
                a.status = hltp_pkg::ST_FULL;
            end else if (shadow_key[pos] != '0) begin
                a.status = hltp_pkg::ST_PRESENT;
            end else begin
                shadow_key[pos] = k;
                shadow_val[pos] = v;
                shadow_entries++;
                a.status = hltp_pkg::ST_OK;
                a.value  = v;
            end
        end else if (op == hltp_pkg::REQ_REMOVE) begin
            pos = locate(k, 1'b0);
            if (pos >= 0) begin
                shift_back(hltp_pkg::t_slot'(pos));
                a.status = hltp_pkg::ST_OK;
            end
        end
        a.count = hltp_pkg::t_count'(shadow_entries);
        return a;
    endfunction

    function automatic int gap_cycles(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_req(input hltp_pkg::t_req op, input hltp_pkg::t_key k,
                            input hltp_pkg::t_value v);
        int gap;
        req_ch.valid    = 1'b1;
        req_ch.req_type = op;
        req_ch.key      = k;
        req_ch.value_in = v;
        do @(posedge i_clk); while (!req_ch.ready);
        answers_due.push_back(apply_request(op, k, v));
        @(negedge i_clk);
        gap = gap_cycles(send_idle_on);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // response checker and back-pressure
    initial begin
        t_answer e;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: response with none pending: status %0d value %h count %0d",
                             $time, rsp_ch.status, rsp_ch.value_out, rsp_ch.entry_count);
                    failed = 1'b1;
                end else begin
                    e = answers_due.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, rsp_ch.status);
                        failed = 1'b1;
                    end
                    if (rsp_ch.value_out !== e.value) begin
                        $display("%0t: value_out expected %h actual %h",
                                 $time, e.value, rsp_ch.value_out);
                        failed = 1'b1;
                    end
                    if (rsp_ch.entry_count !== e.count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, e.count, rsp_ch.entry_count);
                        failed = 1'b1;
                    end
                end
            end
            @(negedge i_clk);
            if (!recv_idle_on) rsp_ch.ready = 1'b1;
            else rsp_ch.ready = ($urandom_range(0, 99) < 70);
            if (recv_idle_on && $urandom_range(0, 99) < 3) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end
        end
    end

    function automatic hltp_pkg::t_key pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 92) return '0;
        return $urandom();
    endfunction

    function automatic hltp_pkg::t_req pick_op(input int w_find, input int w_ins,
                                               input int w_rem);
        int r;
        r = $urandom_range(0, w_find + w_ins + w_rem + 1);
        if (r < w_find) return hltp_pkg::REQ_FIND;
        if (r < w_find + w_ins) return hltp_pkg::REQ_INSERT;
        if (r < w_find + w_ins + w_rem) return hltp_pkg::REQ_REMOVE;
        return hltp_pkg::REQ_NONE;
    endfunction

    task automatic test_key_zero();
        send_req(hltp_pkg::REQ_FIND, '0, '1);
        send_req(hltp_pkg::REQ_INSERT, '0, 32'h1234_5678);
        send_req(hltp_pkg::REQ_REMOVE, '0, '0);
        send_req(hltp_pkg::REQ_NONE, '0, '0);
    endtask

    task automatic test_basic_ops();
        send_req(hltp_pkg::REQ_FIND, 32'hffff_ffff, '0);
        send_req(hltp_pkg::REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        send_req(hltp_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0000);
        send_req(hltp_pkg::REQ_FIND, 32'hffff_ffff, '0);
        send_req(hltp_pkg::REQ_FIND, 32'h0000_0001, '1);
        send_req(hltp_pkg::REQ_INSERT, 32'hffff_ffff, 32'h5555_aaaa);  // already present
        send_req(hltp_pkg::REQ_FIND, 32'hffff_ffff, '0);
        send_req(hltp_pkg::REQ_NONE, 32'hffff_ffff, '1);               // unused type
        send_req(hltp_pkg::REQ_REMOVE, 32'h8000_0000, '0);             // missing key
        send_req(hltp_pkg::REQ_REMOVE, 32'hffff_ffff, '0);
        send_req(hltp_pkg::REQ_FIND, 32'hffff_ffff, '0);
        send_req(hltp_pkg::REQ_REMOVE, 32'h0000_0001, '0);
    endtask

    // keys homed around the wrap point build a chain across slot 0
    task automatic test_wrap_chain();
        hltp_pkg::t_key  chain [$];
        hltp_pkg::t_key  k;
        hltp_pkg::t_slot h;
        while (chain.size() < 8) begin
            k = $urandom();
            h = home_of(k);
            if (k != '0 && (h >= hltp_pkg::t_slot'(hltp_pkg::CAPACITY - 2) ||
                            h <= hltp_pkg::t_slot'(1))) chain.push_back(k);
        end
        foreach (chain[i]) send_req(hltp_pkg::REQ_INSERT, chain[i], $urandom());
        send_req(hltp_pkg::REQ_REMOVE, chain[0], '0);
        send_req(hltp_pkg::REQ_REMOVE, chain[3], '0);
        foreach (chain[i]) send_req(hltp_pkg::REQ_FIND, chain[i], '0);
        foreach (chain[i]) key_pool.push_back(chain[i]);
    endtask

    task automatic run_random(input int n, input int wf, input int wi, input int wr);
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_req(pick_op(wf, wi, wr), pick_key(), $urandom());
        end
    endtask

    // load the table with insert-heavy random requests
    task automatic test_fill();
        run_random(350, 10, 80, 10);
    endtask

    task automatic test_churn();
        run_random(950, 35, 30, 35);
    endtask

    task automatic test_drain();
        run_random(350, 15, 10, 75);
    endtask

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = hltp_pkg::REQ_FIND;
        req_ch.key      = '0;
        req_ch.value_in = '0;
        failed          = 1'b0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        shadow_entries  = 0;
        foreach (shadow_key[i]) begin
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end
        while (key_pool.size() < 300)
            key_pool.push_back(hltp_pkg::t_key'($urandom_range(1, 32'hffff_fffe)));
        key_pool.push_back(32'hffff_ffff);
        key_pool.push_back(32'h0000_0001);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_key_zero();
        test_basic_ops();
        test_wrap_chain();
        test_fill();
        test_churn();
        test_drain();
        req_ch.valid = 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // worst case is long backward-shift walks on a nearly full table
    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

endmodule
